/* hw/rtl/mqm_pkg.sv */
// Package with the types, constants and helper functions of the multi-queue mailbox.
package mqm_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int QUEUE_COUNT = 6;

  // Queues in this range raise notify on a successful send.
  localparam int NOTIFY_LO = 1;
  localparam int NOTIFY_HI = 5;

  localparam int QUEUE_W = 3;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QID_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SLOTS   = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [QUEUE_W:0]   QCNT_CMP  = (QUEUE_W + 1)'(QUEUE_COUNT);
  localparam logic [QUEUE_W-1:0] NOTE_LO_Q = QUEUE_W'(NOTIFY_LO);
  localparam logic [QUEUE_W-1:0] NOTE_HI_Q = QUEUE_W'(NOTIFY_HI);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [ADDR_W-1:0]  DEPTH_A   = ADDR_W'(QUEUE_DEPTH);
  localparam logic [31:0]        FIRST_NUM = 32'd1;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RECV = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUEUE = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [QUEUE_W-1:0] queue;
    logic [3:0]         msg_type;
    logic [2:0]         sender;
    logic [2:0]         addressee;
    logic [31:0]        stamp;
    logic [8:0]         byte_count;
    logic [7:0]         priority_req;
    logic               ack_wanted;
    logic               ack_done;
    logic [63:0]        payload;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] message_number;
    logic [3:0]  out_type;
    logic [2:0]  out_sender;
    logic [2:0]  out_addressee;
    logic [31:0] out_stamp;
    logic [8:0]  out_size;
    logic [7:0]  out_priority;
    logic        out_ack_wanted;
    logic        out_ack_done;
    logic [63:0] out_payload;
    logic        notify;
  } result_t;

  // One stored message: number, timestamp, payload and header fields.
  typedef struct packed {
    logic [31:0] number;
    logic [31:0] stamp;
    logic [63:0] payload;
    logic [3:0]  msg_type;
    logic [2:0]  sender;
    logic [2:0]  addressee;
    logic [8:0]  byte_count;
    logic [7:0]  priority_req;
    logic        ack_wanted;
    logic        ack_done;
  } mem_word_t;

  localparam int MEM_W = $bits(mem_word_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;
    logic accept;
    logic load_read;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;
    logic read_hit;
    logic out_busy;
  } sts_t;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

endpackage

/* hw/rtl/multi_queue_mailbox_top.sv */
// Top level of the multi-queue mailbox: controller and datapath joined together.
//
// The mailbox keeps QUEUE_COUNT ring queues of QUEUE_DEPTH messages each in one
// memory with a registered read port. A send beat appends a message to its queue
// and stamps it with a global message number that starts at 1 and wraps at 32
// bits; a receive beat pops the oldest message and a peek beat returns it while
// leaving it in place. Every command beat yields exactly one result beat with a
// status of ok, bad queue, full or empty. Sends, rejected commands and the
// reserved command code have their result loaded at acceptance; successful
// receives and peeks wait for the registered memory read, whose message comes
// out in the cycle after the address is presented. So the block takes one command
// per cycle for sends and failures when input does not stall, and no new command
// while a successful read is in flight. A result register separates the two
// sides, so a new command is accepted while the previous result is being taken,
// and input stalls only while a read is in flight or an earlier result is held
// by stall. The message store is not cleared after reset; only written entries
// are ever read, so the block is usable in the first cycle after reset.
module multi_queue_mailbox_top
  import mqm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  request_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output result_t  rsp
);

  ctl_t ctl;
  sts_t sts;

  // The controller decides when a command beat is taken and when a memory
  // read result is moved into the result register.
  mqm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .ctl(ctl)
  );

  // The datapath holds the queue pointers, counts, message number counter,
  // message memory and the result register.
  mqm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .req_valid(req_valid),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  assign req_stall = !ctl.ready;

endmodule

/* hw/rtl/mqm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mqm_ctrl.sv */
// Controller state machine that sequences command acceptance and memory reads.
module mqm_ctrl
  import mqm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl.ready     = 1'b0;
    ctl.accept    = 1'b0;
    ctl.load_read = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctl.ready  = !sts.out_busy;
        ctl.accept = sts.req_valid && !sts.out_busy;
        if (ctl.accept && sts.read_hit) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        // Read data is ready; it moves to the result register once that is free.
        if (!sts.out_busy) begin
          ctl.load_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/mqm_dp.sv */
// Datapath: queue pointers and counts, message store and result register.
module mqm_dp
  import mqm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ctl_t     ctl,
  output sts_t     sts,
  input  logic     req_valid,
  input  request_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output result_t  rsp
);

  logic [IDX_W-1:0] head  [QUEUE_COUNT];
  logic [IDX_W-1:0] tail  [QUEUE_COUNT];
  logic [CNT_W-1:0] count [QUEUE_COUNT];
  logic [31:0]      next_number;

  logic             q_ok;
  logic [QID_W-1:0] q_idx;
  logic [CNT_W-1:0] cnt_sel;
  logic [IDX_W-1:0] head_sel;
  logic [IDX_W-1:0] tail_sel;
  logic             is_read;
  logic             send_ok;
  logic             read_hit;
  logic             pop_ok;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  mem_word_t        wword;
  logic [MEM_W-1:0] rdata;
  mem_word_t        rword;
  result_t          imm_result;
  result_t          rd_result;
  logic             out_free;

  assign q_ok     = {1'b0, req.queue} < QCNT_CMP;
  assign q_idx    = req.queue[QID_W-1:0];
  assign cnt_sel  = q_ok ? count[q_idx] : '0;
  assign head_sel = q_ok ? head[q_idx] : '0;
  assign tail_sel = q_ok ? tail[q_idx] : '0;
  assign is_read  = (req.command == CMD_RECV) || (req.command == CMD_PEEK);
  assign send_ok  = (req.command == CMD_SEND) && q_ok && (cnt_sel != CNT_FULL);
  assign read_hit = is_read && q_ok && (cnt_sel != '0);
  assign pop_ok   = (req.command == CMD_RECV) && read_hit;

  assign base_addr = ADDR_W'(q_idx) * DEPTH_A;
  assign waddr     = base_addr + ADDR_W'(tail_sel);
  assign raddr     = base_addr + ADDR_W'(head_sel);

  assign out_free = !rsp_valid || !rsp_stall;

  assign sts.req_valid = req_valid;
  assign sts.read_hit  = read_hit;
  assign sts.out_busy  = !out_free;

  always_comb begin
    wword.number       = next_number;
    wword.stamp        = req.stamp;
    wword.payload      = req.payload;
    wword.msg_type     = req.msg_type;
    wword.sender       = req.sender;
    wword.addressee    = req.addressee;
    wword.byte_count   = req.byte_count;
    wword.priority_req = req.priority_req;
    wword.ack_wanted   = req.ack_wanted;
    wword.ack_done     = req.ack_done;
  end

  mqm_ram #(
    .WIDTH(MEM_W),
    .DEPTH(SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ctl.accept && send_ok),
    .waddr(waddr),
    .wdata(MEM_W'(wword)),
    .re   (ctl.accept && read_hit),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rword = mem_word_t'(rdata);

  // Results that need no stored message are settled at acceptance.
  always_comb begin
    imm_result = '0;
    case (req.command)
      CMD_NONE: imm_result.status = ST_OK;
      default: begin
        if (!q_ok) begin
          imm_result.status = ST_BAD_QUEUE;
        end else if (req.command == CMD_SEND) begin
          if (send_ok) begin
            imm_result.status         = ST_OK;
            imm_result.message_number = next_number;
            imm_result.notify         = (req.queue >= NOTE_LO_Q) && (req.queue <= NOTE_HI_Q);
          end else begin
            imm_result.status = ST_FULL;
          end
        end else begin
          imm_result.status = ST_EMPTY;
        end
      end
    endcase
  end

  always_comb begin
    rd_result                = '0;
    rd_result.status         = ST_OK;
    rd_result.message_number = rword.number;
    rd_result.out_type       = rword.msg_type;
    rd_result.out_sender     = rword.sender;
    rd_result.out_addressee  = rword.addressee;
    rd_result.out_stamp      = rword.stamp;
    rd_result.out_size       = rword.byte_count;
    rd_result.out_priority   = rword.priority_req;
    rd_result.out_ack_wanted = rword.ack_wanted;
    rd_result.out_ack_done   = rword.ack_done;
    rd_result.out_payload    = rword.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      next_number <= FIRST_NUM;
    end else if (ctl.accept) begin
      if (send_ok) begin
        tail[q_idx]  <= wrap_next(tail_sel);
        count[q_idx] <= cnt_sel + 1'b1;
        next_number  <= next_number + 1'b1;
      end else if (pop_ok) begin
        head[q_idx]  <= wrap_next(head_sel);
        count[q_idx] <= cnt_sel - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((ctl.accept && !read_hit) || ctl.load_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_read) begin
      rsp <= rd_result;
    end else if (ctl.accept && !read_hit) begin
      rsp <= imm_result;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the multi-queue mailbox: directed table, then random traffic.
module tb_top;
  import mqm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Number of counted command beats after which the stimulus stops. Reserved
  // commands and bad queue numbers do not count, since the block only bounces them.
  localparam int ITEM_TARGET = 1500;
  // The last stretch of the run is driven with no idling on either side.
  localparam int QUIET_TAIL = 150;
  // A successful receive or peek passes through the registered memory read before its result is loaded.
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  // Ways to fill the message fields of a command beat.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  request_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  result_t  rsp;

  multi_queue_mailbox_top uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // One row of the directed table. When typed is set, want holds a result that
  // is obvious from the command alone; otherwise the mailbox model decides.
  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } plan_row_t;

  plan_row_t plan[$];

  // Results owed by the block, oldest first, one per accepted command beat.
  result_t expected_results[$];

  // Mirror of the mailbox: one ring per queue inside a shared message store,
  // with per-queue head, tail and fill count and the global message number.
  mem_word_t   box_mem [SLOTS];
  int          box_head [QUEUE_COUNT];
  int          box_tail [QUEUE_COUNT];
  int          box_fill [QUEUE_COUNT];
  logic [31:0] box_next_num;

  int mismatches;
  int beats_counted;
  bit idle_on;

  // The clock runs free with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run (roughly 1600 beats, each slowed at
  // most by one sender gap, one result stall burst and the block's memory read).
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Mailbox model: applies one accepted command to the mirror state and
  // returns the result beat the block must produce for it.
  function automatic result_t mailbox_predict(input request_t r);
    result_t   res;
    mem_word_t w;
    int        q;
    int        slot;
    res = '0;
    q = int'(r.queue);
    // The reserved command code is answered with an all-zero ok result.
    if (r.command == CMD_NONE) return res;
    if (q >= QUEUE_COUNT) begin
      res.status = ST_BAD_QUEUE;
      return res;
    end
    if (r.command == CMD_SEND) begin
      if (box_fill[q] >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        return res;
      end
      slot = q * QUEUE_DEPTH + box_tail[q];
      w.number       = box_next_num;
      w.stamp        = r.stamp;
      w.payload      = r.payload;
      w.msg_type     = r.msg_type;
      w.sender       = r.sender;
      w.addressee    = r.addressee;
      w.byte_count   = r.byte_count;
      w.priority_req = r.priority_req;
      w.ack_wanted   = r.ack_wanted;
      w.ack_done     = r.ack_done;
      box_mem[slot] = w;
      // A send reports only the number it was given; the number wraps at 32 bits.
      res.message_number = box_next_num;
      res.notify = (q >= NOTIFY_LO) && (q <= NOTIFY_HI);
      box_next_num = box_next_num + 32'd1;
      box_tail[q] = (box_tail[q] + 1) % QUEUE_DEPTH;
      box_fill[q]++;
      return res;
    end
    if (box_fill[q] == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    // Receive and peek both return the oldest message; only receive pops it.
    w = box_mem[q * QUEUE_DEPTH + box_head[q]];
    res.message_number = w.number;
    res.out_type       = w.msg_type;
    res.out_sender     = w.sender;
    res.out_addressee  = w.addressee;
    res.out_stamp      = w.stamp;
    res.out_size       = w.byte_count;
    res.out_priority   = w.priority_req;
    res.out_ack_wanted = w.ack_wanted;
    res.out_ack_done   = w.ack_done;
    res.out_payload    = w.payload;
    if (r.command == CMD_RECV) begin
      box_head[q] = (box_head[q] + 1) % QUEUE_DEPTH;
      box_fill[q]--;
    end
    return res;
  endfunction

  // Builds one command beat. Random content covers every bit of every field;
  // most byte counts stay within 0 to 256, a few use the whole 9 bits.
  function automatic request_t make_req(input cmd_t c, input int q, input int fill);
    request_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), 2'($urandom())};
    if ($urandom_range(0, 7) != 0) r.byte_count = 9'($urandom_range(0, 256));
    if (fill == FILL_ZEROS) r = '0;
    if (fill == FILL_ONES) r = '1;
    r.command = c;
    r.queue   = QUEUE_W'(q);
    return r;
  endfunction

  function automatic result_t status_only(input status_t s);
    result_t res;
    res = '0;
    res.status = s;
    return res;
  endfunction

  // A successful send result: only the message number and notify are set.
  function automatic result_t sent_as(input int num, input bit note);
    result_t res;
    res = '0;
    res.message_number = 32'(num);
    res.notify = note;
    return res;
  endfunction

  task automatic add_row(input cmd_t c, input int q, input int fill, input bit typed,
                         input result_t want);
    plan_row_t row;
    row.req   = make_req(c, q, fill);
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // Directed table. It starts from the reset state, so the first sends get
  // message numbers 1, 2 and 3 and every failure code can be read off directly.
  task automatic build_plan();
    // Reads of an empty queue right after reset.
    add_row(CMD_RECV, 0, FILL_RANDOM, 1'b1, status_only(ST_EMPTY));
    add_row(CMD_PEEK, 0, FILL_RANDOM, 1'b1, status_only(ST_EMPTY));
    // Queue numbers past the last queue are rejected for send, receive and peek.
    add_row(CMD_SEND, 6, FILL_ONES,   1'b1, status_only(ST_BAD_QUEUE));
    add_row(CMD_RECV, 7, FILL_RANDOM, 1'b1, status_only(ST_BAD_QUEUE));
    add_row(CMD_PEEK, 6, FILL_RANDOM, 1'b1, status_only(ST_BAD_QUEUE));
    // The reserved command leaves the state alone and answers all zeros,
    // even with a bad queue number.
    add_row(CMD_NONE, 0, FILL_ZEROS,  1'b1, status_only(ST_OK));
    add_row(CMD_NONE, 7, FILL_ONES,   1'b1, status_only(ST_OK));
    // Queue 0 never raises notify; queues 1 and 5 bound the notify range.
    // The all-ones send also carries a byte count above 256.
    add_row(CMD_SEND, 0, FILL_ZEROS,  1'b1, sent_as(1, 1'b0));
    add_row(CMD_SEND, 5, FILL_ONES,   1'b1, sent_as(2, 1'b1));
    add_row(CMD_SEND, 1, FILL_RANDOM, 1'b1, sent_as(3, 1'b1));
    // Peek leaves the message in place, receive removes it.
    add_row(CMD_PEEK, 0, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 0, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 0, FILL_RANDOM, 1'b1, status_only(ST_EMPTY));
    add_row(CMD_PEEK, 5, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 5, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 1, FILL_RANDOM, 1'b0, '0);
    // Several queues in flight at once, read back in a different order.
    add_row(CMD_SEND, 2, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_SEND, 3, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_SEND, 4, FILL_ZEROS,  1'b0, '0);
    add_row(CMD_SEND, 2, FILL_ONES,   1'b0, '0);
    add_row(CMD_PEEK, 2, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 2, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 2, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 3, FILL_RANDOM, 1'b0, '0);
    add_row(CMD_RECV, 4, FILL_RANDOM, 1'b0, '0);
  endtask

  // Presents one command beat and holds it until the block takes it. The
  // model runs at the acceptance edge, so its state follows the block's order.
  task automatic drive_beat(input request_t r, input bit typed, input result_t typed_want);
    result_t want;
    int      gap;
    if (beats_counted + QUIET_TAIL >= ITEM_TARGET) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = mailbox_predict(r);
    expected_results.push_back(typed ? typed_want : want);
    if (r.command != CMD_NONE && int'(r.queue) < QUEUE_COUNT) beats_counted++;
  endtask

  // Holds the sender off until every owed result has come out. It always
  // spends at least one edge, so valid is never lowered and raised in one step.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Random mix over all queues. The send weight is drawn per stretch, so some
  // stretches build queues up and others drain them.
  task automatic mixed_traffic(input int beats);
    int   send_w;
    int   pick;
    int   q;
    cmd_t c;
    send_w = $urandom_range(4, 12);
    repeat (beats) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) c = CMD_NONE;
      else if (pick <= send_w) c = CMD_SEND;
      else if (pick <= send_w + 5) c = CMD_PEEK;
      else c = CMD_RECV;
      q = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      drive_beat(make_req(c, q, FILL_RANDOM), 1'b0, '0);
    end
  endtask

  // Fills one queue to the brim, pushes a few sends into the full queue, then
  // empties it with receives and peeks and reads past the empty point.
  task automatic fill_and_drain();
    int   q;
    int   extra;
    cmd_t c;
    q = $urandom_range(0, QUEUE_COUNT - 1);
    extra = $urandom_range(1, 3);
    while (box_fill[q] < QUEUE_DEPTH) drive_beat(make_req(CMD_SEND, q, FILL_RANDOM), 1'b0, '0);
    repeat (extra) drive_beat(make_req(CMD_SEND, q, FILL_RANDOM), 1'b0, '0);
    while (box_fill[q] > 0) begin
      c = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_RECV;
      drive_beat(make_req(c, q, FILL_RANDOM), 1'b0, '0);
    end
    repeat (extra) begin
      c = ($urandom_range(0, 1) == 0) ? CMD_PEEK : CMD_RECV;
      drive_beat(make_req(c, q, FILL_RANDOM), 1'b0, '0);
    end
  endtask

  // Compares one result beat, field by field, with the oldest expectation.
  task automatic check_result(input result_t got);
    result_t want;
    string   diffs;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("result beat with nothing owed: %h", got);
      return;
    end
    want = expected_results.pop_front();
    diffs = "";
    if (got.status         !== want.status)         diffs = {diffs, " status"};
    if (got.message_number !== want.message_number) diffs = {diffs, " message_number"};
    if (got.out_type       !== want.out_type)       diffs = {diffs, " out_type"};
    if (got.out_sender     !== want.out_sender)     diffs = {diffs, " out_sender"};
    if (got.out_addressee  !== want.out_addressee)  diffs = {diffs, " out_addressee"};
    if (got.out_stamp      !== want.out_stamp)      diffs = {diffs, " out_stamp"};
    if (got.out_size       !== want.out_size)       diffs = {diffs, " out_size"};
    if (got.out_priority   !== want.out_priority)   diffs = {diffs, " out_priority"};
    if (got.out_ack_wanted !== want.out_ack_wanted) diffs = {diffs, " out_ack_wanted"};
    if (got.out_ack_done   !== want.out_ack_done)   diffs = {diffs, " out_ack_done"};
    if (got.out_payload    !== want.out_payload)    diffs = {diffs, " out_payload"};
    if (got.notify         !== want.notify)         diffs = {diffs, " notify"};
    if (diffs != "") begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result mismatch in%s: expected %h, got %h", diffs, want, got);
      end
    end
  endtask

  // Result side. Signals are sampled at the edge before any update lands, so
  // this sees exactly the valid and stall that decided the handshake.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_result(rsp);
  end

  // Result stall comes in bursts of random length while idling is enabled.
  initial begin : stall_gen
    int left;
    left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) left--;
      else if (idle_on && $urandom_range(0, 4) == 0) left = $urandom_range(1, 6);
      rsp_stall <= (left > 0);
    end
  end

  // Main sequence: reset, directed table, random stretches, drain, verdict.
  initial begin : stimulus
    int seg;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    idle_on   = 1'b0;
    mismatches    = 0;
    beats_counted = 0;
    box_next_num  = FIRST_NUM;
    for (int i = 0; i < QUEUE_COUNT; i++) begin
      box_head[i] = 0;
      box_tail[i] = 0;
      box_fill[i] = 0;
    end
    build_plan();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    foreach (plan[i]) drive_beat(plan[i].req, plan[i].typed, plan[i].want);
    // The sender waits here until the directed results have all come out.
    wait_for_drain();

    // Random part. The second stretch always runs a queue to full and back,
    // later ones do so now and then; idling is switched per stretch so that
    // some stretches run at full rate. The sender no longer pauses once the
    // quiet tail has begun.
    seg = 0;
    while (beats_counted < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (seg == 1 || $urandom_range(0, 7) == 0) fill_and_drain();
      else mixed_traffic($urandom_range(10, 60));
      if (beats_counted + QUIET_TAIL < ITEM_TARGET && $urandom_range(0, 1) == 0) begin
        wait_for_drain();
      end
      seg++;
    end

    idle_on = 1'b0;
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // A few more edges so that any stray result beat is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
